/* src/vsge_pkg.sv */
// Package for the VCF SNP genotype extractor: constants, types and the base code table.
`timescale 1ns / 1ps

package vsge_pkg;

    localparam int unsigned MAX_SAMPLES = 1024;
    localparam int unsigned NAME_BYTES  = 8;
    localparam int unsigned POS_BITS    = 32;

    localparam int unsigned CFG_INDEX_BITS = 8;
    localparam int unsigned CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_HEADER_BYTES = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_INDEX = CFG_INDEX_BITS'(1);

    localparam logic [10:0] FIELD_SAT      = 11'd2047;
    localparam logic [10:0] FIELD_CHROM    = 11'd0;
    localparam logic [10:0] FIELD_POS      = 11'd1;
    localparam logic [10:0] FIELD_REF      = 11'd3;
    localparam logic [10:0] FIELD_ALT      = 11'd4;
    localparam logic [11:0] SAMPLE_FIELD0  = 12'd8;

    localparam logic [7:0] CHAR_LF       = 8'h0a;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_ONE      = 8'h31;
    localparam logic [7:0] DIGIT_BIAS    = 8'd48;
    localparam logic [7:0] HET_MASK      = 8'hf7;
    localparam logic [7:0] OFFSET_SAT    = 8'd255;
    localparam logic [7:0] GT_SECOND_OFF = 8'd2;

    typedef logic [7:0]          byte_t;
    typedef logic [POS_BITS-1:0] pos_t;

    typedef struct packed {
        logic [10:0] field_number;
        byte_t       field_offset;
        logic [63:0] name_shift;
        byte_t       name_len;
        pos_t        position_acc;
        byte_t       ref_base;
        byte_t       alt_base;
        logic        ref_single;
        logic        alt_single;
        byte_t       allele_first;
        byte_t       allele_second;
    } line_state_t;

    function automatic byte_t base_code_of(byte_t c);
        byte_t u;
        byte_t code;
        u = c;
        if (c >= 8'h61 && c <= 8'h7a) begin
            u = c - 8'h20;
        end
        case (u)
            8'h41:   code = 8'h88; // A
            8'h42:   code = 8'h70; // B
            8'h43:   code = 8'h28; // C
            8'h44:   code = 8'hd0; // D
            8'h47:   code = 8'h48; // G
            8'h48:   code = 8'hb0; // H
            8'h4b:   code = 8'h50; // K
            8'h4d:   code = 8'ha0; // M
            8'h4e:   code = 8'hf0; // N
            8'h52:   code = 8'hc0; // R
            8'h53:   code = 8'h60; // S
            8'h54:   code = 8'h18; // T
            8'h56:   code = 8'he0; // V
            8'h57:   code = 8'h90; // W
            8'h59:   code = 8'h30; // Y
            8'h2d:   code = 8'h04; // gap
            8'h3f:   code = 8'h02; // unknown
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

/* src/vcf_snp_genotype_extractor_top.sv */
// Top level of the VCF SNP genotype extractor: byte parser, line state and result register.
// A result is registered: it appears on m_valid in the cycle after the transaction carrying the closing byte.
// Throughput: one byte per cycle; the only stall is a held result in the output register.
// Header bytes are counted off at the same rate and produce nothing.
// Reset (aresetn low, synchronous): line state and header counter cleared, header_bytes 0,
// sample_index 1, output empty. No clearing pass.
`timescale 1ns / 1ps

module vcf_snp_genotype_extractor_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_data_byte,
    input  logic                                  s_end_of_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [63:0]                           m_chrom_name,
    output logic [7:0]                            m_name_length,
    output logic [31:0]                           m_seq_address,
    output logic [7:0]                            m_base_code,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vsge_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [vsge_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    logic [31:0]           header_bytes_reg;
    logic [10:0]           sample_index_reg;
    logic [31:0]           skip_count_reg, skip_count_next;
    vsge_pkg::line_state_t line_reg, line_next, upd;

    logic                  m_valid_reg, m_valid_next;
    logic [63:0]           chrom_name_reg;
    logic [7:0]            name_length_reg;
    logic [31:0]           seq_address_reg;
    logic [7:0]            base_code_reg;

    logic                  accept;
    logic                  skipping;
    logic                  is_lf, is_tab, close_now, emit;
    logic [11:0]           target;
    logic                  target_ok;
    logic                  hom_ref, hom_alt;
    logic [7:0]            code;
    vsge_pkg::pos_t        pos_minus_one;

    assign s_ready   = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign skipping  = skip_count_reg < header_bytes_reg;
    assign is_lf     = s_data_byte == vsge_pkg::CHAR_LF;
    assign is_tab    = s_data_byte == vsge_pkg::CHAR_TAB;

    assign target    = {1'b0, sample_index_reg} + vsge_pkg::SAMPLE_FIELD0;
    assign target_ok = sample_index_reg != 11'd0
                    && 32'(sample_index_reg) <= 32'(vsge_pkg::MAX_SAMPLES)
                    && target < {1'b0, vsge_pkg::FIELD_SAT};

    // state after the byte, before any line close
    always_comb begin
        upd = line_reg;
        if (is_tab) begin
            if (line_reg.field_number == vsge_pkg::FIELD_REF) begin
                upd.ref_single = line_reg.field_offset == 8'd1;
            end
            if (line_reg.field_number == vsge_pkg::FIELD_ALT) begin
                upd.alt_single = line_reg.field_offset == 8'd1;
            end
            if (line_reg.field_number != vsge_pkg::FIELD_SAT) begin
                upd.field_number = line_reg.field_number + 11'd1;
            end
            upd.field_offset = 8'd0;
        end else if (!is_lf) begin
            unique case (line_reg.field_number)
                vsge_pkg::FIELD_CHROM: begin
                    for (int i = 0; i < int'(vsge_pkg::NAME_BYTES); i++) begin
                        if (line_reg.field_offset == 8'(i)) begin
                            upd.name_shift[63-8*i -: 8] = line_reg.name_shift[63-8*i -: 8]
                                                        | s_data_byte;
                        end
                    end
                    if (line_reg.name_len != vsge_pkg::OFFSET_SAT) begin
                        upd.name_len = line_reg.name_len + 8'd1;
                    end
                end
                vsge_pkg::FIELD_POS: begin
                    upd.position_acc = (line_reg.position_acc << 3)
                                     + (line_reg.position_acc << 1)
                                     + vsge_pkg::pos_t'(s_data_byte)
                                     - vsge_pkg::pos_t'(vsge_pkg::DIGIT_BIAS);
                end
                vsge_pkg::FIELD_REF: begin
                    if (line_reg.field_offset == 8'd0) begin
                        upd.ref_base = s_data_byte;
                    end
                end
                vsge_pkg::FIELD_ALT: begin
                    if (line_reg.field_offset == 8'd0) begin
                        upd.alt_base = s_data_byte;
                    end
                end
                default: ;
            endcase
            if (target_ok && line_reg.field_number == target[10:0]) begin
                if (line_reg.field_offset == 8'd0) begin
                    upd.allele_first = s_data_byte;
                end else if (line_reg.field_offset == vsge_pkg::GT_SECOND_OFF) begin
                    upd.allele_second = s_data_byte;
                end
            end
            if (line_reg.field_offset != vsge_pkg::OFFSET_SAT) begin
                upd.field_offset = line_reg.field_offset + 8'd1;
            end
        end
    end

    assign hom_ref = upd.allele_first == vsge_pkg::CHAR_ZERO
                  && upd.allele_second == vsge_pkg::CHAR_ZERO;
    assign hom_alt = upd.allele_first == vsge_pkg::CHAR_ONE
                  && upd.allele_second == vsge_pkg::CHAR_ONE;
    assign code    = hom_alt ? vsge_pkg::base_code_of(upd.alt_base)
                   : ((vsge_pkg::base_code_of(upd.ref_base)
                       | vsge_pkg::base_code_of(upd.alt_base)) & vsge_pkg::HET_MASK);
    assign pos_minus_one = upd.position_acc - vsge_pkg::pos_t'(1);

    assign close_now = accept && !skipping && (is_lf || s_end_of_data);
    assign emit      = close_now && upd.ref_single && upd.alt_single && !hom_ref;

    always_comb begin
        skip_count_next = skip_count_reg;
        line_next       = line_reg;
        if (accept) begin
            if (skipping) begin
                skip_count_next = skip_count_reg + 32'd1;
            end else if (close_now) begin
                line_next = '0;
            end else begin
                line_next = upd;
            end
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_bytes_reg <= 32'd0;
            sample_index_reg <= 11'd1;
            skip_count_reg   <= 32'd0;
            line_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            skip_count_reg <= skip_count_next;
            line_reg       <= line_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    vsge_pkg::REG_HEADER_BYTES: header_bytes_reg <= cfg_data[31:0];
                    vsge_pkg::REG_SAMPLE_INDEX: sample_index_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            chrom_name_reg  <= upd.name_shift;
            name_length_reg <= upd.name_len;
            seq_address_reg <= 32'(pos_minus_one);
            base_code_reg   <= code;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_chrom_name  = chrom_name_reg;
    assign m_name_length = name_length_reg;
    assign m_seq_address = seq_address_reg;
    assign m_base_code   = base_code_reg;

endmodule

/* src/vsge_checker.sv */
// Port-level assertions for the VCF SNP genotype extractor, bound to the top level.
`timescale 1ns / 1ps

module vsge_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [7:0]                          s_data_byte,
    input logic                                s_end_of_data,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [63:0]                         m_chrom_name,
    input logic [7:0]                          m_name_length,
    input logic [31:0]                         m_seq_address,
    input logic [7:0]                          m_base_code,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [vsge_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input logic [vsge_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // a held result stays put
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chrom_name) && $stable(m_name_length)
                                && $stable(m_seq_address) && $stable(m_base_code))
        else $error("result changed while stalled");

    // input only stalls behind a held result
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output register");

    // a byte that closes no line creates no new transaction
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_end_of_data && s_data_byte != vsge_pkg::CHAR_LF
        |=> !m_valid || $past(m_valid && !m_ready))
        else $error("result without a closed line");

    // configuration is never back-pressured
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind vcf_snp_genotype_extractor_top vsge_checker u_vsge_checker (.*);
